### rtl/heap_sort_engine_assert.svh
// Assertion macros for the heap sort engine checker.
// Included by heap_sort_engine_chk.sv; no other dependencies.
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define HSE_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("heap_sort_engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define HSE_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("heap_sort_engine: next-cycle check failed");

`endif

### rtl/hse_pkg.sv
// Shared types for the heap sort engine: controller command and status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hse_pkg;

  localparam int unsigned DATA_W = 32;

  // Commands from controller to datapath
  typedef struct packed {
    logic ld_item;     // write accepted input item into the store
    logic init_build;  // i = n/2, len = n
    logic rd_build;    // read entry i-1
    logic ld_build;    // cur = entry i-1, pos = i-1, i--
    logic sift_rd;     // read both children of pos
    logic sift_step;   // compare and move one level down
    logic init_sort;   // i = n
    logic rd_sort;     // read root and entry i-1
    logic ld_sort;     // swap root to end, cur = old end, len = i-1, i--
    logic init_out;    // k = 0
    logic rd_out;      // read entry k
    logic ld_out;      // load output register
    logic next_out;    // k++
    logic clear;       // end of run: empty the store
  } hse_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic build_done;  // i == 0
    logic sort_done;   // i <= 1
    logic sift_done;   // sifted value has settled
    logic out_last;    // k addresses the final element
  } hse_sts_t;

endpackage

`default_nettype wire

### rtl/hse_ctrl.sv
// Controller for the heap sort engine: load, heap build, sort-down, emit.
// Depends on hse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hse_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            is_last,
  input  wire logic            out_stall,
  input  wire hse_pkg::hse_sts_t sts,
  output hse_pkg::hse_cmd_t    cmd,
  output logic                 in_stall,
  output logic                 out_valid
);
  import hse_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_BUILD_INIT,
    S_BUILD_CHK,
    S_BUILD_LD,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_SORT_CHK,
    S_SORT_LD,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   sort_phase;
  logic   sort_phase_next;

  // Handshake: items only taken while loading, results only shown while waiting
  assign in_stall  = (state != S_LOAD);
  assign out_valid = (state == S_OUT_WAIT);

  // Next state and command decode
  always_comb begin
    cmd             = '0;
    state_next      = state;
    sort_phase_next = sort_phase;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          if (is_last) state_next = S_BUILD_INIT;
        end
      end
      S_BUILD_INIT: begin
        cmd.init_build  = 1'b1;
        sort_phase_next = 1'b0;
        state_next      = S_BUILD_CHK;
      end
      S_BUILD_CHK: begin
        if (sts.build_done) begin
          cmd.init_sort   = 1'b1;
          sort_phase_next = 1'b1;
          state_next      = S_SORT_CHK;
        end else begin
          cmd.rd_build = 1'b1;
          state_next   = S_BUILD_LD;
        end
      end
      S_BUILD_LD: begin
        cmd.ld_build = 1'b1;
        state_next   = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        cmd.sift_rd = 1'b1;
        state_next  = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        cmd.sift_step = 1'b1;
        if (sts.sift_done) state_next = sort_phase ? S_SORT_CHK : S_BUILD_CHK;
        else               state_next = S_SIFT_RD;
      end
      S_SORT_CHK: begin
        if (sts.sort_done) begin
          cmd.init_out = 1'b1;
          state_next   = S_OUT_RD;
        end else begin
          cmd.rd_sort = 1'b1;
          state_next  = S_SORT_LD;
        end
      end
      S_SORT_LD: begin
        cmd.ld_sort = 1'b1;
        state_next  = S_SIFT_RD;
      end
      S_OUT_RD: begin
        cmd.rd_out = 1'b1;
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.ld_out = 1'b1;
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (!out_stall) begin
          cmd.next_out = 1'b1;
          if (sts.out_last) begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_OUT_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      sort_phase <= 1'b0;
    end else begin
      state      <= state_next;
      sort_phase <= sort_phase_next;
    end
  end

endmodule

`default_nettype wire

### rtl/hse_dp.sv
// Datapath for the heap sort engine: element store, sift unit, indices, output register.
// Depends on hse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hse_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire hse_pkg::hse_cmd_t            cmd,
  output hse_pkg::hse_sts_t                 sts,
  input  wire logic signed [hse_pkg::DATA_W-1:0] value,
  output logic signed [hse_pkg::DATA_W-1:0] sorted_value,
  output logic                              end_of_run,
  output logic                              dropped
);
  import hse_pkg::*;

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned CHW = AW + 2;

  // Element store, one write and two registered reads per cycle
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;
  logic [AW-1:0]            ra;
  logic [AW-1:0]            rb;
  logic                     we;
  logic [AW-1:0]            wa;
  logic signed [DATA_W-1:0] wd;

  logic [CW-1:0]            count;
  logic                     ovf;
  logic [CW-1:0]            i;
  logic [CW-1:0]            im1;
  logic [CW-1:0]            len;
  logic [AW-1:0]            pos;
  logic [CW-1:0]            k;
  logic signed [DATA_W-1:0] cur;

  logic [CHW-1:0]           lc;
  logic [CHW-1:0]           rc;
  logic                     lv;
  logic                     rv;
  logic                     gl;
  logic                     gr;
  logic signed [DATA_W-1:0] tval;
  logic                     has_room;

  assign im1      = i - CW'(1);
  assign has_room = (count < CW'(DEPTH));

  // Children of pos and whether they lie inside the heap
  assign lc = {1'b0, pos, 1'b1};
  assign rc = lc + CHW'(1);
  assign lv = (lc < {{(CHW - CW){1'b0}}, len});
  assign rv = (rc < {{(CHW - CW){1'b0}}, len});

  // Largest of cur and the valid children; ties keep the earlier candidate
  assign gl   = lv && (rd_a > cur);
  assign tval = gl ? rd_a : cur;
  assign gr   = rv && (rd_b > tval);

  assign sts.build_done = (i == '0);
  assign sts.sort_done  = (i <= CW'(1));
  assign sts.sift_done  = !(gl || gr);
  assign sts.out_last   = ((k + CW'(1)) == count);

  // Read address selection
  always_comb begin
    ra = '0;
    rb = '0;
    priority if (cmd.rd_build) begin
      ra = im1[AW-1:0];
    end else if (cmd.sift_rd) begin
      ra = lv ? lc[AW-1:0] : '0;
      rb = rv ? rc[AW-1:0] : '0;
    end else if (cmd.rd_sort) begin
      rb = im1[AW-1:0];
    end else if (cmd.rd_out) begin
      ra = k[AW-1:0];
    end
  end

  // Write port selection
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = value;
    priority if (cmd.ld_item) begin
      we = has_room;
      wa = count[AW-1:0];
      wd = value;
    end else if (cmd.sift_step) begin
      we = 1'b1;
      wa = pos;
      wd = gr ? rd_b : (gl ? rd_a : cur);
    end else if (cmd.ld_sort) begin
      we = 1'b1;
      wa = im1[AW-1:0];
      wd = rd_a;
    end
  end

  // Store
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // Fill count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.clear) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.ld_item) begin
      if (has_room) count <= count + CW'(1);
      else          ovf   <= 1'b1;
    end
  end

  // Loop indices and the value being sifted
  always_ff @(posedge clk) begin
    if (cmd.init_build) begin
      i   <= count >> 1;
      len <= count;
    end
    if (cmd.init_sort) i <= count;
    if (cmd.ld_build) begin
      cur <= rd_a;
      pos <= im1[AW-1:0];
      i   <= im1;
    end
    if (cmd.ld_sort) begin
      cur <= rd_b;
      pos <= '0;
      len <= im1;
      i   <= im1;
    end
    if (cmd.sift_step) begin
      if (gr)      pos <= rc[AW-1:0];
      else if (gl) pos <= lc[AW-1:0];
    end
    if (cmd.init_out) k <= '0;
    if (cmd.next_out) k <= k + CW'(1);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      sorted_value <= rd_a;
      end_of_run   <= sts.out_last;
      dropped      <= ovf;
    end
  end

endmodule

`default_nettype wire

### rtl/heap_sort_engine.sv
// Loading: one item per cycle while in_valid is high. After the last item come heap build
// and sort-down; each sift level reads both children from the store, then compares them.
// Each result is then read, loaded into the output register and held until it is taken.
// One set is handled at a time; items are stalled from the last item until the final result.
// Reset (synchronous, active high) empties the store and clears the overflow flag;
// store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module heap_sort_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [hse_pkg::DATA_W-1:0] value,
  input  wire logic                         is_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [hse_pkg::DATA_W-1:0] sorted_value,
  output logic                              end_of_run,
  output logic                              dropped
);
  import hse_pkg::*;

  hse_cmd_t cmd;
  hse_sts_t sts;

  // Sequencer
  hse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_last   (is_last),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // Store and sift unit
  hse_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .sorted_value (sorted_value),
    .end_of_run   (end_of_run),
    .dropped      (dropped)
  );

endmodule

`default_nettype wire

### rtl/heap_sort_engine_chk.sv
// Port-level checker for the heap sort engine, bound to the top level.
// Depends on heap_sort_engine_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

module heap_sort_engine_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [31:0] value,
  input wire logic        is_last,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] sorted_value,
  input wire logic        end_of_run,
  input wire logic        dropped
);

`include "heap_sort_engine_assert.svh"

  // No item is taken while a result is on offer
  `HSE_ASSERT_NOW(a_no_load_while_emit, clk, rst, out_valid, in_stall)

  // Once the last item of a set is taken, the block is busy sorting
  `HSE_ASSERT_NEXT(a_busy_after_last, clk, rst, in_valid && !in_stall && is_last, in_stall)

  // Taking the final result ends the run and reopens the input
  `HSE_ASSERT_NEXT(a_run_ends, clk, rst, out_valid && !out_stall && end_of_run, !out_valid && !in_stall)

  // A stalled result holds
  `HSE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(sorted_value) && $stable(end_of_run) && $stable(dropped))

endmodule

bind heap_sort_engine heap_sort_engine_chk u_chk (.*);

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for heap_sort_engine: sends sets of signed values and checks
// every sorted result against an in-bench heapsort prediction. Depends on hse_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  import hse_pkg::DATA_W;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned STUCK_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam logic signed [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    logic signed [DATA_W-1:0] val;
    logic                     eor;
    logic                     drop;
  } sorted_res_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] value;
  logic                     is_last;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     end_of_run;
  logic                     dropped;

  // idling control, shared by sender task and receiver process
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_request;
  int unsigned errors;

  // predicted state of the block and queue of outstanding sorted results
  logic signed [DATA_W-1:0] set_store [DEPTH];
  int unsigned              set_count;
  logic                     set_overflow;
  sorted_res_t              expected_sorted [$];

  heap_sort_engine #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .end_of_run   (end_of_run),
    .dropped      (dropped)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Heapsort prediction
  // ---------------------------------------------------------------------

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [DATA_W-1:0] t;
    t = set_store[a];
    set_store[a] = set_store[b];
    set_store[b] = t;
  endfunction

  // push the entry at pos down a max-heap of len entries
  function automatic void sift_down(int unsigned pos, int unsigned len);
    int unsigned top;
    bit          settled;
    settled = 1'b0;
    while (!settled) begin
      top = pos;
      if (2 * pos + 1 < len && set_store[2 * pos + 1] > set_store[top]) top = 2 * pos + 1;
      if (2 * pos + 2 < len && set_store[2 * pos + 2] > set_store[top]) top = 2 * pos + 2;
      if (top == pos) begin
        settled = 1'b1;
      end else begin
        swap_entries(pos, top);
        pos = top;
      end
    end
  endfunction

  function automatic void heap_order(int unsigned n);
    for (int unsigned i = n / 2; i > 0; i--) sift_down(i - 1, n);
    for (int unsigned i = n; i > 1; i--) begin
      swap_entries(0, i - 1);
      sift_down(0, i - 1);
    end
  endfunction

  // store one accepted item; a last item yields the whole sorted set
  function automatic void collect_value(logic signed [DATA_W-1:0] v, logic last);
    sorted_res_t r;
    if (set_count < DEPTH) begin
      set_store[set_count] = v;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (last) begin
      heap_order(set_count);
      for (int unsigned k = 0; k < set_count; k++) begin
        r.val  = set_store[k];
        r.eor  = (k + 1 == set_count);
        r.drop = set_overflow;
        expected_sorted.push_back(r);
      end
      set_count = 0;
      set_overflow = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender, receiver, checker, watchdog
  // ---------------------------------------------------------------------

  // offer one item from a falling edge until accepted; returns at a falling edge
  task automatic send_item(logic signed [DATA_W-1:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      value    <= $urandom;
      is_last  <= $urandom_range(1);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    is_last  <= last;
    do @(posedge clk); while (in_stall);
    collect_value(v, last);
    @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] x;
    case ($urandom_range(9))
      0: x = VMIN;
      1: x = VMAX;
      2, 3: begin
        x = $urandom_range(8);
        x = x - 4;
      end
      default: x = $urandom;
    endcase
    return x;
  endfunction

  // receiver stall: a requested hold-off first, otherwise random
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        hold_request = hold_request - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    sorted_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sorted.size() == 0) begin
        $display("%0t: unexpected result: value %0d end_of_run %0b dropped %0b",
                 $time, sorted_value, end_of_run, dropped);
        errors++;
      end else begin
        want = expected_sorted.pop_front();
        if (sorted_value !== want.val) begin
          $display("%0t: sorted_value expected %0d got %0d", $time, want.val, sorted_value);
          errors++;
        end
        if (end_of_run !== want.eor) begin
          $display("%0t: end_of_run expected %0b got %0b", $time, want.eor, end_of_run);
          errors++;
        end
        if (dropped !== want.drop) begin
          $display("%0t: dropped expected %0b got %0b", $time, want.drop, dropped);
          errors++;
        end
      end
    end
  end

  // end the run if neither channel moves an item for too long
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // smallest set: one item
  task automatic test_single();
    send_item(VMAX, 1'b1);
  endtask

  // field extremes and sign boundaries
  task automatic test_extremes();
    send_item(VMAX, 1'b0);
    send_item('0, 1'b0);
    send_item(VMIN, 1'b0);
    send_item(1, 1'b0);
    send_item(VMIN + 1, 1'b0);
    send_item(-1, 1'b1);
  endtask

  // repeated values must come out nondecreasing
  task automatic test_duplicates();
    send_item(7, 1'b0);
    send_item(-3, 1'b0);
    send_item(7, 1'b0);
    send_item(7, 1'b0);
    send_item(-3, 1'b1);
  endtask

  // descending input, worst order for the sort-down
  task automatic test_reverse();
    for (int i = 8; i >= 1; i--) send_item(i, i == 1);
  endtask

  // full store, last item dropped, several items dropped
  task automatic test_overflow();
    foreach (set_store[i]) send_item(pick_value(), i == DEPTH - 1);
    for (int unsigned i = 0; i <= DEPTH; i++) send_item(pick_value(), i == DEPTH);
    for (int unsigned i = 0; i < DEPTH + 3; i++) send_item(pick_value(), i == DEPTH + 2);
  endtask

  // receiver holds off while the sender keeps offering small sets
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_request = 300;
    for (int s = 0; s < 3; s++)
      for (int i = 0; i < 4; i++) send_item(pick_value(), i == 3);
  endtask

  // random sets, mostly small, now and then near or past the store depth
  task automatic test_random_sets(int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(19))
        0:       len = $urandom_range(DEPTH + 2, DEPTH - 4);
        1, 2, 3: len = $urandom_range(40, 9);
        default: len = $urandom_range(8, 1);
      endcase
      for (int unsigned i = 0; i < len; i++) send_item(pick_value(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin : main
    rst          = 1'b1;
    in_valid     = 1'b0;
    value        = '0;
    is_last      = 1'b0;
    errors       = 0;
    set_count    = 0;
    set_overflow = 1'b0;
    hold_request = 0;
    set_idling(0, 0);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single();
    test_extremes();
    test_duplicates();
    set_idling(14, 14);
    test_reverse();
    test_overflow();
    test_backpressure();
    set_idling(0, 0);
    test_random_sets(6);
    set_idling(47, 0);
    test_random_sets(6);
    set_idling(0, 47);
    test_random_sets(6);
    set_idling(14, 14);
    test_random_sets(6);
    in_valid <= 1'b0;

    // drain outstanding results, then let the block settle
    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_sorted.size() != 0) errors++;
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
